/* design/tas_pkg.sv */
// ----------------------------------------------------------------------------
// Tile animation sequencer package
// Shared constants, types and the per-slot record for the slot ring.
// ----------------------------------------------------------------------------
package tas_pkg;

  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam logic [31:0] DISPLAY_BASE_RESET = 32'h0600_4000;

  typedef enum logic [2:0] {
    MODE_IDLE0    = 3'd0,
    MODE_LOOP     = 3'd1,
    MODE_IDLE2    = 3'd2,
    MODE_FWD_ONCE = 3'd3,
    MODE_PINGPONG = 3'd4,
    MODE_REV_ONCE = 3'd5,
    MODE_REV_LOOP = 3'd6,
    MODE_IDLE7    = 3'd7
  } mode_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  delay;
    logic [6:0]  count;
    logic [7:0]  timer;
    logic [7:0]  frame;
    logic [31:0] tiles;
  } slot_rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HOLD
  } state_t;

  // Control from the sequencer to the ring: shift goes to every cell, advance and load pick the head record.
  typedef struct packed {
    logic shift;    // rotate the ring one place
    logic advance;  // the record leaving the head is stepped by its mode
    logic load;     // overwrite the head record with load data
  } ring_ctl_t;

endpackage

/* design/tile_animation_sequencer.sv */
// ----------------------------------------------------------------------------
// Tile animation sequencer
// Sixteen animation slots in a rotating ring of cells, issuing tile copies.
// ----------------------------------------------------------------------------
// The slot records live in a ring of sixteen cells. A load beat rotates the
// ring a full turn, rewriting the addressed slot as it passes the head and
// emitting one copy request; a tick beat rotates the ring a full turn,
// stepping each slot by its mode as it passes the head and emitting a copy
// request for each slot whose frame changed. The ring turns one place per
// cycle unless the output stalls; a tick that emits goes on to HOLD to
// release its last copy. Each copy request may wait in the output register,
// which stalls the rotation until it is taken. The last request caused by a
// beat carries out_tlast; a tick that changes no frame emits nothing. The user
// must write display_base through cfg_wr_en/cfg_wr_data only while the block
// is idle; the block does not enforce this. display_base resets to 0x06004000.
module tile_animation_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata from bit 0: slot[3:0], mode[6:4], frame_delay[14:7],
  // frame_count[21:15], tile_base[53:22], start_at_last[54], zero fill
  input  logic [55:0] in_tdata,
  // in_tuser: req_type
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata from bit 0: copy_source[31:0], copy_destination[63:32],
  // copy_slot[67:64], zero fill
  output logic [71:0] out_tdata,
  output logic        out_tlast
);

  localparam int unsigned N = tas_pkg::SLOT_COUNT;

  logic [31:0] display_base_r;
  always_ff @(posedge clk) begin
    if (!rst_n) display_base_r <= tas_pkg::DISPLAY_BASE_RESET;
    else if (cfg_wr_en) display_base_r <= cfg_wr_data;
  end

  // Beat capture.
  logic        is_load_r;
  logic [3:0]  ld_slot_r;
  tas_pkg::slot_rec_t ld_rec_r;
  logic [3:0]  pos_r, pos_nxt;      // slot index at the head
  logic [4:0]  cnt_r, cnt_nxt;      // rotations done
  tas_pkg::state_t state_r, state_nxt;

  // Ring.
  tas_pkg::slot_rec_t ring [N];
  tas_pkg::slot_rec_t head_in;
  tas_pkg::slot_rec_t stepped;
  logic               changed;
  tas_pkg::ring_ctl_t ctl;

  tas_step u_step (.rec_in(ring[0]), .rec_out(stepped), .changed(changed));

  // The head record leaves cell 0 and re-enters at cell N-1.
  always_comb begin
    head_in = ring[0];
    if (ctl.advance) head_in = stepped;
    if (ctl.load)    head_in = ld_rec_r;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    tas_cell u_cell (
      .clk(clk), .rst_n(rst_n), .shift(ctl.shift),
      .rec_in(g == N - 1 ? head_in : ring[(g + 1) % N]),
      .rec_out(ring[g])
    );
  end

  // Output register.
  logic        ov_r;
  logic [31:0] osrc_r, osrc_nxt, odst_r, odst_nxt;
  logic [3:0]  oslot_r, oslot_nxt;
  logic        olast_r;
  logic        emit;
  logic [7:0]  afr;
  logic [31:0] src_calc;

  // A tick copy waits in a one-deep stage until the next copy or the end of
  // the turn tells whether it was the last one.
  logic        hv_r;
  logic [31:0] hsrc_r, hdst_r;
  logic [3:0]  hslot_r;

  wire out_free = !ov_r || out_tready;
  wire last_turn = (cnt_r == 5'(N - 1));

  always_comb begin
    afr = ctl.load ? ld_rec_r.frame
                   : (stepped.frame[7] ? 8'd0 - stepped.frame : stepped.frame);
    src_calc = (ctl.load ? ld_rec_r.tiles : stepped.tiles)
               + {{17{afr[7]}}, afr, 7'd0};
  end

  // Next state. A tick turn that leaves a copy in the holding stage goes on
  // to HOLD to release it as the last one.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tas_pkg::ST_IDLE:  if (in_tvalid) state_nxt = tas_pkg::ST_SWEEP;
      tas_pkg::ST_SWEEP: if (out_free && last_turn)
                           state_nxt = hv_r || (emit && !is_load_r)
                                       ? tas_pkg::ST_HOLD : tas_pkg::ST_IDLE;
      tas_pkg::ST_HOLD:  if (out_free) state_nxt = tas_pkg::ST_IDLE;
      default:           state_nxt = tas_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    ctl       = '0;
    in_tready = (state_r == tas_pkg::ST_IDLE);
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    emit      = 1'b0;
    osrc_nxt  = osrc_r;
    odst_nxt  = odst_r;
    oslot_nxt = oslot_r;
    unique case (state_r)
      tas_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        pos_nxt = '0;
      end
      tas_pkg::ST_SWEEP: begin
        if (out_free) begin
          ctl.shift = 1'b1;
          if (is_load_r) begin
            ctl.load = (pos_r == ld_slot_r);
            emit     = ctl.load;
          end else begin
            ctl.advance = 1'b1;
            emit        = changed;
          end
          cnt_nxt = cnt_r + 5'd1;
          pos_nxt = pos_r + 4'd1;
        end
      end
      default: ;
    endcase
    if (emit) begin
      osrc_nxt  = src_calc;
      odst_nxt  = display_base_r + {21'd0, pos_r, 7'd0};
      oslot_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tas_pkg::ST_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
      hv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      if (state_r == tas_pkg::ST_IDLE) begin
        hv_r <= 1'b0;
        ov_r <= ov_r && !out_tready;
      end else if (emit && !is_load_r) begin
        // Release the held copy as not last, hold the new one.
        ov_r    <= hv_r || (ov_r && !out_tready);
        hv_r    <= 1'b1;
        hsrc_r  <= osrc_nxt;
        hdst_r  <= odst_nxt;
        hslot_r <= oslot_nxt;
        if (hv_r) begin
          osrc_r  <= hsrc_r;
          odst_r  <= hdst_r;
          oslot_r <= hslot_r;
          olast_r <= 1'b0;
        end
      end else if (emit) begin
        ov_r    <= 1'b1;
        osrc_r  <= osrc_nxt;
        odst_r  <= odst_nxt;
        oslot_r <= oslot_nxt;
        olast_r <= 1'b1;
      end else if (state_r == tas_pkg::ST_HOLD && out_free && hv_r) begin
        ov_r    <= 1'b1;
        osrc_r  <= hsrc_r;
        odst_r  <= hdst_r;
        oslot_r <= hslot_r;
        olast_r <= 1'b1;
        hv_r    <= 1'b0;
      end else begin
        ov_r <= ov_r && !out_tready;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      is_load_r         <= in_tuser;
      ld_slot_r         <= in_tdata[3:0];
      ld_rec_r.mode     <= in_tdata[6:4];
      ld_rec_r.delay    <= in_tdata[14:7];
      ld_rec_r.count    <= in_tdata[21:15];
      ld_rec_r.timer    <= 8'd0;
      ld_rec_r.frame    <= in_tdata[54] ? {1'b0, in_tdata[21:15]} - 8'd1 : 8'd0;
      ld_rec_r.tiles    <= in_tdata[53:22];
    end
  end

  // A tick sweep that emitted ends in HOLD so the held copy goes out last; a
  // load never holds anything and returns to IDLE straight from the sweep.
  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, oslot_r, odst_r, osrc_r};
  assign out_tlast  = olast_r;

endmodule

/* design/tas_cell.sv */
// ----------------------------------------------------------------------------
// Tile animation slot cell
// Holds one slot record and passes it to its neighbor when the ring rotates.
// ----------------------------------------------------------------------------
module tas_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift,
  input  tas_pkg::slot_rec_t rec_in,
  output tas_pkg::slot_rec_t rec_out
);

  tas_pkg::slot_rec_t rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else if (shift) begin
      rec_r <= rec_in;
    end
  end

  assign rec_out = rec_r;

endmodule

/* design/tas_step.sv */
// ----------------------------------------------------------------------------
// Tile animation slot stepper
// Advances one slot record by its playback mode for one tick.
// ----------------------------------------------------------------------------
module tas_step (
  input  tas_pkg::slot_rec_t rec_in,
  output tas_pkg::slot_rec_t rec_out,
  output logic               changed
);

  logic [7:0] last;
  logic [7:0] cnt8;
  logic [7:0] tinc;
  logic       hit;
  logic [7:0] fnext;
  logic       step;

  always_comb begin
    cnt8  = {1'b0, rec_in.count};
    last  = cnt8 - 8'd1;
    tinc  = rec_in.timer + 8'd1;
    hit   = (tinc == rec_in.delay);
    fnext = rec_in.frame;
    step  = 1'b0;
    unique case (tas_pkg::mode_t'(rec_in.mode))
      tas_pkg::MODE_LOOP: begin
        step  = 1'b1;
        fnext = rec_in.frame + 8'd1;
        if (fnext == cnt8) fnext = 8'd0;
      end
      tas_pkg::MODE_FWD_ONCE: begin
        step  = (rec_in.frame != last);
        fnext = rec_in.frame + 8'd1;
      end
      tas_pkg::MODE_PINGPONG: begin
        step  = 1'b1;
        fnext = rec_in.frame + 8'd1;
        if (fnext == cnt8) fnext = 8'd2 - fnext;
      end
      tas_pkg::MODE_REV_ONCE: begin
        step  = (rec_in.frame != 8'd0);
        fnext = rec_in.frame - 8'd1;
      end
      tas_pkg::MODE_REV_LOOP: begin
        step  = 1'b1;
        fnext = rec_in.frame - 8'd1;
        if (fnext[7]) fnext = last;
      end
      default: begin
        step = 1'b0;
      end
    endcase

    rec_out = rec_in;
    changed = 1'b0;
    if (step) begin
      rec_out.timer = hit ? 8'd0 : tinc;
      if (hit) begin
        rec_out.frame = fnext;
        changed       = 1'b1;
      end
    end
  end

endmodule
